/* rtl/core/bes_pkg.sv */
package bes_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 4096;
    localparam int FIFO_DEPTH_DEFAULT = 4;

    // register fields
    localparam int IMAGE_WIDTH_W  = 13;
    localparam int IMAGE_HEIGHT_W = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int COUNT_W        = 4;
    localparam int TDATA_W        = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_CONNECTIVITY_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT      = 2'd2;

    localparam logic MODE_EDGE4 = 1'b0;
    localparam logic MODE_ALL8  = 1'b1;

    // 3x3 window, bit = row * 3 + column, top-left first, new column enters at column 2
    localparam logic [8:0] COL_KEEP_LOW    = 9'h0DB;
    localparam logic [8:0] COL_LEFT        = 9'h049;
    localparam logic [8:0] COL_RIGHT       = 9'h124;
    localparam logic [8:0] ROW_TOP         = 9'h007;
    localparam logic [8:0] ROW_BOTTOM      = 9'h1C0;
    localparam logic [8:0] CENTRE_BIT      = 9'h010;
    localparam logic [8:0] EDGE_NEIGHBOURS = 9'h0AA;
    localparam logic [8:0] ALL_BITS        = 9'h1FF;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } bes_edge_t;

    typedef struct packed {
        logic               last;
        logic [COUNT_W-1:0] count;
        logic               keep;
    } bes_result_t;

    function automatic logic [COUNT_W-1:0] count_set(input logic [8:0] v);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < 9; i++)
        begin
            n = n + {{(COUNT_W-1){1'b0}}, v[i]};
        end
        return n;
    endfunction

endpackage

/* rtl/core/bes_result_fifo.sv */
module bes_result_fifo #(
    parameter int DEPTH = bes_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  bes_pkg::bes_result_t         push_data,
    input  logic                         pop,
    output logic                         out_valid,
    output bes_pkg::bes_result_t         out_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    bes_pkg::bes_result_t entry_reg [DEPTH];

    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/binary_endpoint_strip_3x3.sv */
// Endpoint stripping on a binary raster image: one pixel item per clock, back to back.
// Each accepted item reads one entry of a 2-bit wide line memory (the two rows above) and
// writes it back in the next cycle; a one-entry forward covers a width of one, where
// consecutive items hit the same entry. The result for a pixel leaves image_width+1
// items after that pixel. The item that releases it passes the line memory read, the
// window register and the result queue before the result can be taken. The host follows
// each image with image_width+1 flush items.
// The input holds only while the queue and the two stages ahead of it carry FIFO_DEPTH
// items, which happens only while the receiver holds off.
// The first image_width+1 items of an image give no result. Stale line memory contents
// only ever reach rows outside the image, which are masked, so there is no clearing
// pass after reset. Write image_width or image_height only between images; either
// write restarts the stream.
module binary_endpoint_strip_3x3 #(
    parameter int MAX_WIDTH  = bes_pkg::MAX_WIDTH_DEFAULT,
    parameter int FIFO_DEPTH = bes_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bes_pkg::TDATA_W-1:0]       s_tdata,   // [0] pixel_in
    input  logic                              s_tuser,   // [0] flush
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bes_pkg::TDATA_W-1:0]       m_tdata,   // [0] keep_pixel, [4:1] neighbour_count
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bes_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bes_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int PW   = $clog2(MAX_WIDTH + 2);
    localparam int RW   = bes_pkg::IMAGE_HEIGHT_W;
    localparam int CNTW = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [CW-1:0]      addr;
        logic               bottom;
        logic               fwd;
        logic [1:0]         fwd_data;
        bes_pkg::bes_edge_t edges;
        logic               emit;
        logic               last;
    } stage1_t;

    typedef struct packed {
        bes_pkg::bes_edge_t edges;
        logic               last;
    } stage2_t;

    // configuration, held as effective width-1 and height-1
    logic            mode_reg;
    logic [CW-1:0]   wm1_reg;
    logic [RW-1:0]   hm1_reg;

    // the incoming row runs one past the last image row during the flush
    logic [CW-1:0]   col_reg, col_next;
    logic [RW:0]     row_reg, row_next;
    logic [PW-1:0]   primed_reg, primed_next;

    logic [1:0]      line_mem [MAX_WIDTH];
    logic [1:0]      rd_reg;

    logic            s1_valid_reg;
    stage1_t         s1_reg;
    logic [8:0]      window_reg;
    logic            s2_valid_reg;
    stage2_t         s2_reg;

    logic                             accept;
    logic                             cfg_we;
    logic                             geom_we;
    logic [bes_pkg::IMAGE_WIDTH_W-1:0] width_in;
    logic [RW-1:0]                    height_in;
    logic [CW-1:0]                    ci;
    logic [RW:0]                      row_sub;
    logic [RW-1:0]                    rc;
    bes_pkg::bes_edge_t               edge_in;
    logic                             emit_in;
    logic                             last_in;
    logic                             bottom_in;
    logic [1:0]                       s1_line;
    logic [8:0]                       window_next;
    logic [8:0]                       edge_mask;
    logic [8:0]                       win_m;
    logic [8:0]                       nb_bits;
    bes_pkg::bes_result_t             result;
    bes_pkg::bes_result_t             out_data;
    logic [CNTW-1:0]                  fifo_count;
    logic [CNTW:0]                    credit;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign geom_we   = cfg_we && ((cfg_index == bes_pkg::REG_IMAGE_WIDTH)
                                  || (cfg_index == bes_pkg::REG_IMAGE_HEIGHT));
    assign width_in  = cfg_data[bes_pkg::IMAGE_WIDTH_W-1:0];
    assign height_in = cfg_data[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bes_pkg::MODE_ALL8;
            wm1_reg  <= '0;
            hm1_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bes_pkg::REG_CONNECTIVITY_MODE:
                begin
                    mode_reg <= cfg_data[0];
                end
                bes_pkg::REG_IMAGE_WIDTH:
                begin
                    if (width_in == '0)
                        wm1_reg <= '0;
                    else if (32'(width_in) > MAX_WIDTH)
                        wm1_reg <= CW'(MAX_WIDTH - 1);
                    else
                        wm1_reg <= CW'(width_in - bes_pkg::IMAGE_WIDTH_W'(1));
                end
                bes_pkg::REG_IMAGE_HEIGHT:
                begin
                    hm1_reg <= (height_in == '0) ? '0 : height_in - RW'(1);
                end
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    // position of the incoming item and of the window centre it completes
    assign accept    = s_tvalid && s_tready;
    assign bottom_in = s_tuser ? 1'b0 : s_tdata[0];
    assign ci        = (col_reg > wm1_reg) ? '0 : col_reg;
    assign row_sub   = (ci == '0) ? (RW+1)'(2) : (RW+1)'(1);
    assign rc        = (row_reg >= row_sub) ? RW'(row_reg - row_sub) : '0;

    always_comb
    begin
        edge_in.left   = (ci == '0) ? (wm1_reg == '0) : (ci == CW'(1));
        edge_in.right  = (ci == '0);
        edge_in.top    = (rc == '0);
        edge_in.bottom = (rc >= hm1_reg);
        emit_in        = (primed_reg == PW'(wm1_reg) + PW'(2));
        last_in        = emit_in && edge_in.bottom && edge_in.right;
    end

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        primed_next = primed_reg;
        if (geom_we)
        begin
            col_next    = '0;
            row_next    = '0;
            primed_next = '0;
        end
        else if (accept)
        begin
            if (last_in)
            begin
                col_next    = '0;
                row_next    = '0;
                primed_next = '0;
            end
            else
            begin
                if (ci == wm1_reg)
                begin
                    col_next = '0;
                    row_next = row_reg + (RW+1)'(1);
                end
                else
                begin
                    col_next = ci + CW'(1);
                end
                if (!emit_in)
                begin
                    primed_next = primed_reg + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            primed_reg <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            primed_reg <= primed_next;
        end
    end

    // line memory: bit 1 the row two above, bit 0 the row above
    assign s1_line = s1_reg.fwd ? s1_reg.fwd_data : rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= line_mem[ci];
        end
        if (s1_valid_reg)
        begin
            line_mem[s1_reg.addr] <= {s1_line[0], s1_reg.bottom};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && s1_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.addr     <= ci;
            s1_reg.bottom   <= bottom_in;
            // write-back of the item ahead lands on the same edge as this read
            s1_reg.fwd      <= s1_valid_reg && (s1_reg.addr == ci);
            s1_reg.fwd_data <= {s1_line[0], s1_reg.bottom};
            s1_reg.edges    <= edge_in;
            s1_reg.emit     <= emit_in;
            s1_reg.last     <= last_in;
        end
        if (s1_valid_reg)
        begin
            window_reg   <= window_next;
            s2_reg.edges <= s1_reg.edges;
            s2_reg.last  <= s1_reg.last;
        end
    end

    assign window_next = ((window_reg >> 1) & bes_pkg::COL_KEEP_LOW)
                       | {s1_reg.bottom, 2'b00, s1_line[0], 2'b00, s1_line[1], 2'b00};

    // mask the window at the image border and count
    always_comb
    begin
        edge_mask = '0;
        if (s2_reg.edges.left)
            edge_mask = edge_mask | bes_pkg::COL_LEFT;
        if (s2_reg.edges.right)
            edge_mask = edge_mask | bes_pkg::COL_RIGHT;
        if (s2_reg.edges.top)
            edge_mask = edge_mask | bes_pkg::ROW_TOP;
        if (s2_reg.edges.bottom)
            edge_mask = edge_mask | bes_pkg::ROW_BOTTOM;
        win_m = window_reg & ~edge_mask;
        if (mode_reg == bes_pkg::MODE_ALL8)
            nb_bits = win_m & ~bes_pkg::CENTRE_BIT & bes_pkg::ALL_BITS;
        else
            nb_bits = win_m & bes_pkg::EDGE_NEIGHBOURS;
        result.count = bes_pkg::count_set(nb_bits);
        result.keep  = ((win_m & bes_pkg::CENTRE_BIT) != '0)
                       && (result.count != bes_pkg::COUNT_W'(1));
        result.last  = s2_reg.last;
    end

    bes_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (result),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    // hold input while queued and in-flight items could fill the queue
    assign credit   = {1'b0, fifo_count} + (CNTW+1)'(s1_valid_reg) + (CNTW+1)'(s2_valid_reg);
    assign s_tready = (credit < (CNTW+1)'(FIFO_DEPTH));

    assign m_tdata = {{(bes_pkg::TDATA_W-bes_pkg::COUNT_W-1){1'b0}}, out_data.count,
                      out_data.keep};
    assign m_tlast = out_data.last;

endmodule

/* rtl/core/bes_checker.sv */
module bes_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bes_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tlast
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[4:1] <= 4'd8)
        else $error("neighbour count above eight");

    // an endpoint is never kept
    a_no_endpoint_kept: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[4:1] != 4'd1)
        else $error("pixel with one neighbour kept");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:5] == 3'b000)
        else $error("padding bits of result not zero");

endmodule

bind binary_endpoint_strip_3x3 bes_checker u_bes_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
